// ----- design/vfc_pkg.sv -----
`default_nettype none
package vfc_pkg;

  // request opcodes
  localparam logic [1:0] OP_LOAD_CHUNK = 2'd0;
  localparam logic [1:0] OP_LOAD_WEST  = 2'd1;
  localparam logic [1:0] OP_LOAD_SOUTH = 2'd2;
  localparam logic [1:0] OP_EMIT       = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_AIR       = 3'd0;
  localparam logic [2:0] CFG_WATER     = 3'd1;
  localparam logic [2:0] CFG_UNDEFINED = 3'd2;
  localparam logic [2:0] CFG_WEST      = 3'd3;
  localparam logic [2:0] CFG_SOUTH     = 3'd4;

  // face normal axes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // widest stored block kind
  localparam int KindMax = 16;
  typedef logic [KindMax-1:0] kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] cell_x;
    logic [5:0] cell_y;
    logic [3:0] cell_z;
    logic [7:0] block_kind;
  } request_t;

  typedef struct packed {
    logic [3:0]  face_x;
    logic [5:0]  face_y;
    logic [3:0]  face_z;
    logic [1:0]  axis;
    logic        swapped;
    logic [7:0]  solid_kind;
    logic [15:0] face_number;
    logic        last;
  } result_t;

  // transparency codes shared by the face judges
  typedef struct packed {
    logic [7:0] air;
    logic [7:0] water;
    logic [7:0] undefined;
  } codes_t;

  // outcome for one boundary
  typedef struct packed {
    logic  found;
    logic  swapped;
    kind_t kind;
  } face_t;

endpackage
`default_nettype wire

// ----- design/vfc_ram.sv -----
`default_nettype none
module vfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- design/vfc_face_judge.sv -----
`default_nettype none
module vfc_face_judge (
  input  wire vfc_pkg::codes_t codes,
  input  wire vfc_pkg::kind_t  center,
  input  wire vfc_pkg::kind_t  nbr,
  input  wire logic            border,
  input  wire logic            present,
  input  wire logic            invert,
  output vfc_pkg::face_t       face
);

  logic cell_clear, cell_solid, nbr_clear, nbr_solid;

  // transparency classes
  assign cell_clear = (center == vfc_pkg::kind_t'(codes.air)) ||
                      (center == vfc_pkg::kind_t'(codes.water));
  assign cell_solid = !cell_clear && (center != vfc_pkg::kind_t'(codes.undefined));
  assign nbr_clear  = (nbr == vfc_pkg::kind_t'(codes.air)) ||
                      (nbr == vfc_pkg::kind_t'(codes.water));
  assign nbr_solid  = !nbr_clear && (nbr != vfc_pkg::kind_t'(codes.undefined));

  // across a chunk border only a clear cell facing a solid plane cell counts
  always_comb begin
    face.found   = 1'b0;
    face.swapped = 1'b0;
    face.kind    = nbr;
    if (!border || present) begin
      if (cell_clear && nbr_solid) begin
        face.found   = 1'b1;
        face.swapped = !invert;
        face.kind    = nbr;
      end else if (!border && nbr_clear && cell_solid) begin
        face.found   = 1'b1;
        face.swapped = invert;
        face.kind    = center;
      end
    end
  end

endmodule
`default_nettype wire

// ----- design/voxel_face_culler.sv -----
`default_nettype none
// Voxel face culler. Loads (chunk cell, west plane cell, south plane cell) are
// taken while idle and never raise busy. An emit reads the cell and its
// -x, -y and -z neighbours through the single port of the chunk memory, one read
// a cycle, then judges the three boundaries and holds busy until its last face
// is out; its 0 to 3 faces come out on consecutive cycles, each marked by strobe
// for one cycle, and the receiver cannot stall them. An emit outside the chunk
// gives no face and does not raise busy.
module voxel_face_culler #(
  parameter int SIZE_X    = 16,
  parameter int SIZE_Y    = 64,
  parameter int SIZE_Z    = 16,
  parameter int KIND_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire vfc_pkg::request_t request,
  output logic                   strobe,
  output vfc_pkg::result_t       result,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data
);

  localparam int ChunkDepth = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int WestDepth  = SIZE_Y * SIZE_Z;
  localparam int SouthDepth = SIZE_Y * SIZE_X;
  localparam int CAW = $clog2(ChunkDepth);
  localparam int WAW = $clog2(WestDepth);
  localparam int SAW = $clog2(SouthDepth);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CAP, S_EMIT} state_t;

  state_t           state;
  logic [1:0]       step;
  logic [3:0]       cx, cz;
  logic [5:0]       cy;
  logic [CAW-1:0]   cell_addr;
  vfc_pkg::kind_t   c_kind, ax_kind, ay_kind;
  vfc_pkg::face_t   faces [3];
  logic [2:0]       pend;
  logic [15:0]      face_counter;
  vfc_pkg::codes_t  codes;
  logic             west_present, south_present;

  logic             x_ok, y_ok, z_ok, accept;
  logic [CAW-1:0]   req_addr, chunk_addr;
  logic [WAW-1:0]   west_addr;
  logic [SAW-1:0]   south_addr;
  logic             chunk_we, west_we, south_we;
  logic [KIND_BITS-1:0] wkind, chunk_rdata, west_rdata, south_rdata;
  vfc_pkg::kind_t   chunk_kind, west_kind, south_kind;
  vfc_pkg::face_t   fx, fy, fz;
  logic [1:0]       sel;
  logic [2:0]       remain;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // range checks and addresses of the request
  assign x_ok = int'(request.cell_x) < SIZE_X;
  assign y_ok = int'(request.cell_y) < SIZE_Y;
  assign z_ok = int'(request.cell_z) < SIZE_Z;
  assign req_addr = CAW'(int'(request.cell_x) + int'(request.cell_y) * SIZE_X
                         + int'(request.cell_z) * (SIZE_X * SIZE_Y));
  assign wkind = KIND_BITS'(request.block_kind);

  // write enables for loads
  assign chunk_we = accept && (request.op == vfc_pkg::OP_LOAD_CHUNK) && x_ok && y_ok && z_ok;
  assign west_we  = accept && (request.op == vfc_pkg::OP_LOAD_WEST) && y_ok && z_ok;
  assign south_we = accept && (request.op == vfc_pkg::OP_LOAD_SOUTH) && x_ok && y_ok;

  // chunk port: cell, then -x, -y, -z neighbours
  always_comb begin
    chunk_addr = req_addr;
    if (state == S_READ) begin
      case (step)
        2'd0:    chunk_addr = cell_addr;
        2'd1:    chunk_addr = cell_addr - CAW'(1);
        2'd2:    chunk_addr = cell_addr - CAW'(SIZE_X);
        default: chunk_addr = cell_addr - CAW'(SIZE_X * SIZE_Y);
      endcase
    end
  end

  // plane addresses follow the request when idle, the held cell otherwise
  always_comb begin
    if (state == S_IDLE) begin
      west_addr  = WAW'(int'(request.cell_y) * SIZE_Z + int'(request.cell_z));
      south_addr = SAW'(int'(request.cell_y) * SIZE_X + int'(request.cell_x));
    end else begin
      west_addr  = WAW'(int'(cy) * SIZE_Z + int'(cz));
      south_addr = SAW'(int'(cy) * SIZE_X + int'(cx));
    end
  end

  vfc_ram #(.WIDTH(KIND_BITS), .DEPTH(ChunkDepth)) u_chunk (
    .clk(clk), .we(chunk_we), .addr(chunk_addr), .wdata(wkind), .rdata(chunk_rdata)
  );
  vfc_ram #(.WIDTH(KIND_BITS), .DEPTH(WestDepth)) u_west (
    .clk(clk), .we(west_we), .addr(west_addr), .wdata(wkind), .rdata(west_rdata)
  );
  vfc_ram #(.WIDTH(KIND_BITS), .DEPTH(SouthDepth)) u_south (
    .clk(clk), .we(south_we), .addr(south_addr), .wdata(wkind), .rdata(south_rdata)
  );

  assign chunk_kind = vfc_pkg::kind_t'(chunk_rdata);
  assign west_kind  = vfc_pkg::kind_t'(west_rdata);
  assign south_kind = vfc_pkg::kind_t'(south_rdata);

  // boundary decisions, made when the -z neighbour arrives
  vfc_face_judge u_judge_x (
    .codes(codes), .center(c_kind), .nbr((cx == 4'd0) ? west_kind : ax_kind),
    .border(cx == 4'd0), .present(west_present), .invert(1'b0), .face(fx)
  );
  vfc_face_judge u_judge_y (
    .codes(codes), .center(c_kind), .nbr(ay_kind),
    .border(cy == 6'd0), .present(1'b0), .invert(1'b1), .face(fy)
  );
  vfc_face_judge u_judge_z (
    .codes(codes), .center(c_kind), .nbr((cz == 4'd0) ? south_kind : chunk_kind),
    .border(cz == 4'd0), .present(south_present), .invert(1'b0), .face(fz)
  );

  // lowest pending axis goes out first
  always_comb begin
    if (pend[0]) begin
      sel = vfc_pkg::AXIS_X;
    end else if (pend[1]) begin
      sel = vfc_pkg::AXIS_Y;
    end else begin
      sel = vfc_pkg::AXIS_Z;
    end
    remain = pend & ~(3'b001 << sel);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.air       <= 8'd0;
      codes.water     <= 8'd1;
      codes.undefined <= 8'd255;
      west_present    <= 1'b0;
      south_present   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        vfc_pkg::CFG_AIR:       codes.air       <= cfg_data;
        vfc_pkg::CFG_WATER:     codes.water     <= cfg_data;
        vfc_pkg::CFG_UNDEFINED: codes.undefined <= cfg_data;
        vfc_pkg::CFG_WEST:      west_present    <= cfg_data[0];
        vfc_pkg::CFG_SOUTH:     south_present   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      step         <= 2'd0;
      pend         <= 3'b000;
      face_counter <= 16'd0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (chunk_we || west_we || south_we) begin
            face_counter <= 16'd0;
          end
          if (accept && request.op == vfc_pkg::OP_EMIT && x_ok && y_ok && z_ok) begin
            cx        <= request.cell_x;
            cy        <= request.cell_y;
            cz        <= request.cell_z;
            cell_addr <= req_addr;
            step      <= 2'd0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          case (step)
            2'd1:    c_kind  <= chunk_kind;
            2'd2:    ax_kind <= chunk_kind;
            2'd3:    ay_kind <= chunk_kind;
            default: ;
          endcase
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_CAP;
          end
        end
        S_CAP: begin
          faces[0] <= fx;
          faces[1] <= fy;
          faces[2] <= fz;
          pend     <= {fz.found, fy.found, fx.found};
          state    <= (fx.found || fy.found || fz.found) ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          strobe             <= 1'b1;
          result.face_x      <= cx;
          result.face_y      <= cy;
          result.face_z      <= cz;
          result.axis        <= sel;
          result.swapped     <= faces[sel].swapped;
          result.solid_kind  <= faces[sel].kind[7:0];
          result.face_number <= face_counter;
          result.last        <= (remain == 3'b000);
          face_counter       <= face_counter + 16'd1;
          pend               <= remain;
          if (remain == 3'b000) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/vfc_checker.sv -----
`default_nettype none
module vfc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire vfc_pkg::request_t request,
  input wire logic              strobe,
  input wire vfc_pkg::result_t  result,
  input wire logic              cfg_we,
  input wire logic [2:0]        cfg_index,
  input wire logic [7:0]        cfg_data
);

  // reset leaves the block quiet
  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("output after reset");

  // a face only follows busy work
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("face transfer without a pending emit");

  // faces of one cell come back to back
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a cell's faces");

  // face numbers run on within a cell
  a_number: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> result.face_number == $past(result.face_number) + 16'd1)
    else $error("face number skipped");

  // the last face ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("face after last");

endmodule

bind voxel_face_culler vfc_checker u_vfc_checker (.*);
`default_nettype wire

// ----- tb/sv/vfc_checker.sv -----
`default_nettype none
module vfc_scoreboard (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire vfc_pkg::request_t request,
  input  wire logic              strobe,
  input  wire vfc_pkg::result_t  result,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  output int                     fails,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the block state
  logic [7:0]  chunk_mem [16384];
  logic [7:0]  west_mem [1024];
  logic [7:0]  south_mem [1024];
  logic [15:0] face_count;
  logic [7:0]  air_q, water_q, undef_q;
  logic        west_on, south_on;

  vfc_pkg::result_t faces_due [$];

  function automatic logic is_clear(logic [7:0] t);
    return t == air_q || t == water_q;
  endfunction

  function automatic logic is_solid(logic [7:0] t);
    return !is_clear(t) && t != undef_q;
  endfunction

  // one boundary: {found, swapped, kind}; across a chunk border only clear-over-solid counts
  function automatic logic [9:0] judge(logic [7:0] c, logic [7:0] a, logic border,
                                       logic swap_clear);
    if (is_clear(c) && is_solid(a)) return {1'b1, swap_clear, a};
    if (!border && is_clear(a) && is_solid(c)) return {1'b1, !swap_clear, c};
    return '0;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  // apply one accepted request: record a load, or work out the faces of an emit
  task automatic predict_faces(vfc_pkg::request_t r);
    logic [9:0] j [3];
    logic [1:0] axes [3];
    logic [7:0] c;
    vfc_pkg::result_t e;
    int n;
    n = 0;
    case (r.op)
      vfc_pkg::OP_LOAD_CHUNK: begin
        chunk_mem[{r.cell_z, r.cell_y, r.cell_x}] = r.block_kind;
        face_count = '0;
      end
      vfc_pkg::OP_LOAD_WEST: begin
        west_mem[{r.cell_y, r.cell_z}] = r.block_kind;
        face_count = '0;
      end
      vfc_pkg::OP_LOAD_SOUTH: begin
        south_mem[{r.cell_y, r.cell_x}] = r.block_kind;
        face_count = '0;
      end
      default: begin
        c = chunk_mem[{r.cell_z, r.cell_y, r.cell_x}];
        j[0] = '0; j[1] = '0; j[2] = '0;
        axes[0] = vfc_pkg::AXIS_X; axes[1] = vfc_pkg::AXIS_Y; axes[2] = vfc_pkg::AXIS_Z;
        if (r.cell_x != 0)
          j[0] = judge(c, chunk_mem[{r.cell_z, r.cell_y, r.cell_x - 4'd1}], 1'b0, 1'b1);
        else if (west_on)
          j[0] = judge(c, west_mem[{r.cell_y, r.cell_z}], 1'b1, 1'b1);
        if (r.cell_y != 0)
          j[1] = judge(c, chunk_mem[{r.cell_z, r.cell_y - 6'd1, r.cell_x}], 1'b0, 1'b0);
        if (r.cell_z != 0)
          j[2] = judge(c, chunk_mem[{r.cell_z - 4'd1, r.cell_y, r.cell_x}], 1'b0, 1'b1);
        else if (south_on)
          j[2] = judge(c, south_mem[{r.cell_y, r.cell_x}], 1'b1, 1'b1);
        for (int k = 0; k < 3; k++) begin
          if (j[k][9]) begin
            e.face_x = r.cell_x;
            e.face_y = r.cell_y;
            e.face_z = r.cell_z;
            e.axis = axes[k];
            e.swapped = j[k][8];
            e.solid_kind = j[k][7:0];
            e.face_number = face_count;
            e.last = 1'b0;
            face_count = face_count + 16'd1;
            faces_due.push_back(e);
            n++;
          end
        end
        if (n > 0) faces_due[faces_due.size() - 1].last = 1'b1;
      end
    endcase
  endtask

  // compare one face against the oldest expectation
  task automatic check_face(vfc_pkg::result_t g);
    vfc_pkg::result_t e;
    if (faces_due.size() == 0) begin
      report("unexpected face", 32'(g.face_number), 32'd0);
      return;
    end
    e = faces_due.pop_front();
    if (g.face_x != e.face_x) report("face_x", 32'(g.face_x), 32'(e.face_x));
    if (g.face_y != e.face_y) report("face_y", 32'(g.face_y), 32'(e.face_y));
    if (g.face_z != e.face_z) report("face_z", 32'(g.face_z), 32'(e.face_z));
    if (g.axis != e.axis) report("axis", 32'(g.axis), 32'(e.axis));
    if (g.swapped != e.swapped) report("swapped", 32'(g.swapped), 32'(e.swapped));
    if (g.solid_kind != e.solid_kind)
      report("solid_kind", 32'(g.solid_kind), 32'(e.solid_kind));
    if (g.face_number != e.face_number)
      report("face_number", 32'(g.face_number), 32'(e.face_number));
    if (g.last != e.last) report("last", 32'(g.last), 32'(e.last));
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  // watch config writes, request transfers and face strobes
  always @(posedge clk) begin
    if (rst) begin
      face_count = '0;
      air_q = 8'd0;
      water_q = 8'd1;
      undef_q = 8'd255;
      west_on = 1'b0;
      south_on = 1'b0;
      faces_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vfc_pkg::CFG_AIR:       air_q = cfg_data;
          vfc_pkg::CFG_WATER:     water_q = cfg_data;
          vfc_pkg::CFG_UNDEFINED: undef_q = cfg_data;
          vfc_pkg::CFG_WEST:      west_on = cfg_data[0];
          vfc_pkg::CFG_SOUTH:     south_on = cfg_data[0];
          default: ;
        endcase
      end
      if (strobe) check_face(result);
      if (start && !busy) predict_faces(request);
    end
    pending = faces_due.size();
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  vfc_pkg::request_t request = '0;
  logic     strobe;
  vfc_pkg::result_t  result;
  logic     cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int       fails;
  int       pending;

  // which entries have been loaded, so no emit reads an unwritten one
  bit chunk_done [16384];
  bit west_done [1024];
  bit south_done [1024];
  logic [7:0] air_c = 8'd0, water_c = 8'd1, undef_c = 8'd255;
  int burst_left = 0;

  voxel_face_culler u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  vfc_scoreboard u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .strobe(strobe), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fails(fails), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  // one request transfer, then maybe a gap when the burst runs out
  task automatic send(vfc_pkg::request_t r);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 7))
      0: return air_c;
      1: return water_c;
      2: return undef_c;
      3: return 8'($urandom);
      default: return 8'($urandom_range(2, 5));
    endcase
  endfunction

  task automatic load(logic [1:0] op, logic [3:0] x, logic [5:0] y, logic [3:0] z,
                      logic [7:0] k);
    vfc_pkg::request_t r;
    r = '{op: op, cell_x: x, cell_y: y, cell_z: z, block_kind: k};
    case (op)
      vfc_pkg::OP_LOAD_CHUNK: chunk_done[{z, y, x}] = 1'b1;
      vfc_pkg::OP_LOAD_WEST:  west_done[{y, z}] = 1'b1;
      default:                south_done[{y, x}] = 1'b1;
    endcase
    send(r);
  endtask

  // load whatever an emit at this cell reads, then emit
  task automatic emit(logic [3:0] x, logic [5:0] y, logic [3:0] z);
    vfc_pkg::request_t r;
    if (!chunk_done[{z, y, x}]) load(vfc_pkg::OP_LOAD_CHUNK, x, y, z, pick_kind());
    if (x != 0 && !chunk_done[{z, y, x - 4'd1}])
      load(vfc_pkg::OP_LOAD_CHUNK, x - 4'd1, y, z, pick_kind());
    if (y != 0 && !chunk_done[{z, y - 6'd1, x}])
      load(vfc_pkg::OP_LOAD_CHUNK, x, y - 6'd1, z, pick_kind());
    if (z != 0 && !chunk_done[{z - 4'd1, y, x}])
      load(vfc_pkg::OP_LOAD_CHUNK, x, y, z - 4'd1, pick_kind());
    if (x == 0 && !west_done[{y, z}])
      load(vfc_pkg::OP_LOAD_WEST, 4'($urandom), y, z, pick_kind());
    if (z == 0 && !south_done[{y, x}])
      load(vfc_pkg::OP_LOAD_SOUTH, x, y, 4'($urandom), pick_kind());
    r = '{op: vfc_pkg::OP_EMIT, cell_x: x, cell_y: y, cell_z: z, block_kind: 8'($urandom)};
    send(r);
  endtask

  // settle, then write the whole register set
  task automatic configure(logic [7:0] a, logic [7:0] w, logic [7:0] u, logic wp,
                           logic sp);
    logic [7:0] vals [5];
    logic [2:0] idx [5];
    vals = '{a, w, u, {7'd0, wp}, {7'd0, sp}};
    idx = '{vfc_pkg::CFG_AIR, vfc_pkg::CFG_WATER, vfc_pkg::CFG_UNDEFINED,
            vfc_pkg::CFG_WEST, vfc_pkg::CFG_SOUTH};
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (12) @(negedge clk);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    air_c = a;
    water_c = w;
    undef_c = u;
  endtask

  // mostly small neighborhoods loaded and emitted, with loose loads mixed in
  task automatic random_phase(int count);
    logic [3:0] x, z;
    logic [5:0] y;
    for (int i = 0; i < count; i++) begin
      x = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1) * 15) : 4'($urandom);
      y = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 1) * 63) : 6'($urandom);
      z = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 1) * 15) : 4'($urandom);
      case ($urandom_range(0, 9))
        0, 1: load(2'($urandom_range(0, 2)), x, y, z, pick_kind());
        2:    load(vfc_pkg::OP_LOAD_CHUNK, x, y, z, 8'($urandom));
        default: emit(x, y, z);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme coordinates and kinds, borders off then on
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd0, 6'd0, 4'd0, 8'd0);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd15, 6'd63, 4'd15, 8'd255);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd14, 6'd63, 4'd15, 8'd0);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd15, 6'd62, 4'd15, 8'd1);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd15, 6'd63, 4'd14, 8'd2);
    emit(4'd15, 6'd63, 4'd15);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd15, 6'd63, 4'd15, 8'd7);
    emit(4'd15, 6'd63, 4'd15);
    emit(4'd15, 6'd63, 4'd15);
    load(vfc_pkg::OP_LOAD_WEST, 4'd9, 6'd0, 4'd0, 8'd9);
    load(vfc_pkg::OP_LOAD_SOUTH, 4'd0, 6'd0, 4'd6, 8'd255);
    emit(4'd0, 6'd0, 4'd0);
    configure(8'd0, 8'd1, 8'd255, 1'b1, 1'b1);
    emit(4'd0, 6'd0, 4'd0);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd0, 6'd0, 4'd0, 8'd5);
    emit(4'd0, 6'd0, 4'd0);
    load(vfc_pkg::OP_LOAD_WEST, 4'd0, 6'd63, 4'd15, 8'd3);
    load(vfc_pkg::OP_LOAD_CHUNK, 4'd0, 6'd63, 4'd15, 8'd1);
    emit(4'd0, 6'd63, 4'd15);

    random_phase(20);
    configure(8'd255, 8'd0, 8'd128, 1'b1, 1'b1);
    random_phase(20);
    configure(8'd7, 8'd7, 8'd0, 1'b1, 1'b0);
    random_phase(20);
    configure(8'd0, 8'd1, 8'd255, 1'b0, 1'b1);
    random_phase(20);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
